@@ src/direct_mapped_cache_tag_check_defines.svh @@
// Assertion macros for the direct-mapped cache tag check.
// Used by the port checker; expects clk and rst_n in the including scope.
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dmc_pkg.sv @@
// Shared types and constants for the direct-mapped cache tag check.
// No dependencies; used by every module of the block.
`default_nettype none

package dmc_pkg;

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_CLOCK = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd4;
  localparam logic [CFG_W-1:0] CACHE_CLOCK_RST = 4'd1;

  // Legal ranges of the registers
  localparam logic [CFG_W-1:0] OFFSET_BITS_MAX = 4'd12;
  localparam logic [CFG_W-1:0] INDEX_BITS_MIN  = 4'd1;
  localparam logic [CFG_W-1:0] INDEX_BITS_MAX  = 4'd10;
  localparam logic [CFG_W-1:0] CACHE_CLOCK_MIN = 4'd1;
  localparam logic [CFG_W-1:0] CACHE_CLOCK_MAX = 4'd10;

  // Largest line count the index field can address
  localparam int INDEX_LIMIT = 1024;

  // Result field widths
  localparam int INDEX_OUT_W = 10;
  localparam int TAG_OUT_W   = 23;
  localparam int COUNT_W     = 32;
  localparam int AVG_W       = 16;
  localparam int FRAC_W      = 8;

  // Average access time: hit_time + MISS_PENALTY * misses / accesses
  localparam int MISS_PENALTY = 120;
  localparam int PENALTY_Q8   = MISS_PENALTY << FRAC_W;
  localparam int QUOT_W       = 15;
  localparam int PROD_W       = COUNT_W + QUOT_W;
  localparam int DIV_STEPS    = QUOT_W;
  localparam int STEP_W       = $clog2(DIV_STEPS + 1);

  // Queue between lookup and divider
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CFG_W-1:0] offset_bits;
    logic [CFG_W-1:0] index_bits;
    logic [CFG_W-1:0] cache_clock;
  } cfg_t;

  // One classified access waiting for its average time
  typedef struct packed {
    logic                   hit;
    logic [INDEX_OUT_W-1:0] line_index;
    logic [TAG_OUT_W-1:0]   tag_value;
    logic [COUNT_W-1:0]     access_count;
    logic [COUNT_W-1:0]     hit_count;
    logic [COUNT_W-1:0]     miss_count;
    logic [CFG_W-1:0]       hit_time;
  } entry_t;

endpackage

`default_nettype wire

@@ src/dmc_queue.sv @@
// Small FIFO of classified accesses between the lookup front and the divider.
// Depends on dmc_pkg for entry_t and the queue depth.
`default_nettype none

module dmc_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire dmc_pkg::entry_t             push_entry,
  input  wire logic                        pop,
  output dmc_pkg::entry_t                  pop_entry,
  output logic                             not_empty,
  output logic [dmc_pkg::QCNT_W-1:0]       count
);

  dmc_pkg::entry_t                 slot_r [dmc_pkg::QUEUE_DEPTH];
  logic [dmc_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [dmc_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [dmc_pkg::QCNT_W-1:0]      count_r;
  logic [dmc_pkg::QCNT_W-1:0]      count_nxt;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + dmc_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - dmc_pkg::QCNT_W'(1);
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + dmc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + dmc_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign pop_entry = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

`default_nettype wire

@@ src/dmc_front.sv @@
// Lookup front: splits the address, reads and updates the line store,
// keeps the access counters and pushes one classified beat per access.
// Depends on dmc_pkg.
`default_nettype none

module dmc_front #(
  parameter int ADDRESS_WIDTH = 24,
  parameter int MAX_LINES     = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dmc_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ADDRESS_WIDTH-1:0]   in_address,
  input  wire logic [dmc_pkg::QCNT_W-1:0] q_count,
  output logic                            push,
  output dmc_pkg::entry_t                 push_entry
);

  localparam int LINE_DEPTH = (MAX_LINES < dmc_pkg::INDEX_LIMIT) ? MAX_LINES
                                                                 : dmc_pkg::INDEX_LIMIT;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int TAG_W      = ADDRESS_WIDTH - 1;
  localparam int RED_W      = 2 * dmc_pkg::INDEX_OUT_W;
  localparam int SHIFT_W    = dmc_pkg::CFG_W + 1;

  // Reduce the index field to the implemented line count
  function automatic logic [IDX_W-1:0] line_of(input logic [dmc_pkg::INDEX_OUT_W-1:0] f);
    logic [RED_W-1:0] v;
    logic [RED_W-1:0] d;
    v = RED_W'(f);
    for (int k = dmc_pkg::INDEX_OUT_W - 1; k >= 0; k--) begin
      d = RED_W'(LINE_DEPTH) << k;
      if (v >= d) begin
        v = v - d;
      end
    end
    return IDX_W'(v);
  endfunction

  function automatic logic [dmc_pkg::COUNT_W-1:0] sat_inc(
    input logic [dmc_pkg::COUNT_W-1:0] v
  );
    return (v == '1) ? v : v + dmc_pkg::COUNT_W'(1);
  endfunction

  // Line store: valid bits cleared by a sweep, tags written on use
  logic             valid_mem [LINE_DEPTH];
  logic [TAG_W-1:0] tag_mem   [LINE_DEPTH];

  logic                  clr_active_r;
  logic [IDX_W-1:0]      clr_idx_r;

  logic [dmc_pkg::CFG_W-1:0]       ob;
  logic [dmc_pkg::CFG_W-1:0]       ib;
  logic [dmc_pkg::CFG_W-1:0]       hit_time;
  logic [SHIFT_W-1:0]              tag_shift;
  logic [dmc_pkg::INDEX_OUT_W-1:0] idx_mask;
  logic [dmc_pkg::INDEX_OUT_W-1:0] idx_field;
  logic [IDX_W-1:0]                idx;
  logic [TAG_W-1:0]                tag;
  logic                            accept;

  logic              s1_valid_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic              vrd_r;
  logic [TAG_W-1:0]  trd_r;
  logic              fwd_r;
  logic [TAG_W-1:0]  fwd_tag_r;

  logic              line_valid;
  logic [TAG_W-1:0]  line_tag;
  logic              hit;

  logic [dmc_pkg::COUNT_W-1:0] acc_cnt_r;
  logic [dmc_pkg::COUNT_W-1:0] hit_cnt_r;
  logic [dmc_pkg::COUNT_W-1:0] miss_cnt_r;
  logic [dmc_pkg::COUNT_W-1:0] acc_cnt_nxt;
  logic [dmc_pkg::COUNT_W-1:0] hit_cnt_nxt;
  logic [dmc_pkg::COUNT_W-1:0] miss_cnt_nxt;

  // Clamp the field widths and hit time to their legal ranges
  always_comb begin
    ob = (cfg.offset_bits > dmc_pkg::OFFSET_BITS_MAX) ? dmc_pkg::OFFSET_BITS_MAX
                                                      : cfg.offset_bits;
    if (cfg.index_bits < dmc_pkg::INDEX_BITS_MIN) begin
      ib = dmc_pkg::INDEX_BITS_MIN;
    end else if (cfg.index_bits > dmc_pkg::INDEX_BITS_MAX) begin
      ib = dmc_pkg::INDEX_BITS_MAX;
    end else begin
      ib = cfg.index_bits;
    end
    if (cfg.cache_clock < dmc_pkg::CACHE_CLOCK_MIN) begin
      hit_time = dmc_pkg::CACHE_CLOCK_MIN;
    end else if (cfg.cache_clock > dmc_pkg::CACHE_CLOCK_MAX) begin
      hit_time = dmc_pkg::CACHE_CLOCK_MAX;
    end else begin
      hit_time = cfg.cache_clock;
    end
  end

  // Split the address into index and tag
  always_comb begin
    tag_shift = SHIFT_W'(ob) + SHIFT_W'(ib);
    idx_mask  = (dmc_pkg::INDEX_OUT_W'(1) << ib) - dmc_pkg::INDEX_OUT_W'(1);
    idx_field = dmc_pkg::INDEX_OUT_W'(in_address >> ob) & idx_mask;
    idx       = line_of(idx_field);
    tag       = TAG_W'(in_address >> tag_shift);
  end

  // Hold off while clearing or while the queue could overflow
  assign in_ready = !clr_active_r &&
                    ((q_count + dmc_pkg::QCNT_W'(s1_valid_r)) <
                     dmc_pkg::QCNT_W'(dmc_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  // Clearing sweep over the valid bits after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == IDX_W'(LINE_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
    end
  end

  // Valid store: clear sweep or mark the accessed line
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      valid_mem[clr_idx_r] <= 1'b0;
    end else if (s1_valid_r) begin
      valid_mem[s1_idx_r] <= 1'b1;
    end
    if (accept) begin
      vrd_r <= valid_mem[idx];
    end
  end

  // Tag store: a hit rewrites the same tag, so every access writes
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      tag_mem[s1_idx_r] <= s1_tag_r;
    end
    if (accept) begin
      trd_r <= tag_mem[idx];
    end
  end

  // Lookup stage registers; forward the line written in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r  <= idx;
      s1_tag_r  <= tag;
      fwd_r     <= s1_valid_r && (s1_idx_r == idx);
      fwd_tag_r <= s1_tag_r;
    end
  end

  // Compare and update the statistics
  always_comb begin
    line_valid   = fwd_r ? 1'b1 : vrd_r;
    line_tag     = fwd_r ? fwd_tag_r : trd_r;
    hit          = line_valid && (line_tag == s1_tag_r);
    acc_cnt_nxt  = sat_inc(acc_cnt_r);
    hit_cnt_nxt  = hit ? sat_inc(hit_cnt_r) : hit_cnt_r;
    miss_cnt_nxt = hit ? miss_cnt_r : sat_inc(miss_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r  <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (s1_valid_r) begin
      acc_cnt_r  <= acc_cnt_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // Hand the classified beat to the queue
  assign push = s1_valid_r;
  always_comb begin
    push_entry.hit          = hit;
    push_entry.line_index   = dmc_pkg::INDEX_OUT_W'(s1_idx_r);
    push_entry.tag_value    = dmc_pkg::TAG_OUT_W'(s1_tag_r);
    push_entry.access_count = acc_cnt_nxt;
    push_entry.hit_count    = hit_cnt_nxt;
    push_entry.miss_count   = miss_cnt_nxt;
    push_entry.hit_time     = hit_time;
  end

endmodule

`default_nettype wire

@@ src/dmc_back.sv @@
// Divider back end: computes the average access time of each queued beat
// one quotient bit per cycle and holds the result in the output register.
// Depends on dmc_pkg.
`default_nettype none

module dmc_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire dmc_pkg::entry_t                  q_entry,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic [dmc_pkg::INDEX_OUT_W-1:0]       out_line_index,
  output logic [dmc_pkg::TAG_OUT_W-1:0]         out_tag_value,
  output logic [dmc_pkg::COUNT_W-1:0]           out_access_count,
  output logic [dmc_pkg::COUNT_W-1:0]           out_hit_count,
  output logic [dmc_pkg::COUNT_W-1:0]           out_miss_count,
  output logic [dmc_pkg::AVG_W-1:0]             out_avg_access_time_q8
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t                   state_r;
  back_state_t                   state_nxt;
  dmc_pkg::entry_t               ent_r;
  logic [dmc_pkg::COUNT_W-1:0]   rem_r;
  logic [dmc_pkg::QUOT_W-1:0]    sh_r;
  logic [dmc_pkg::STEP_W-1:0]    step_r;

  logic [dmc_pkg::PROD_W-1:0]    prod;
  logic [dmc_pkg::COUNT_W:0]     trial;
  logic [dmc_pkg::COUNT_W:0]     dvs;
  logic                          qbit;
  logic [dmc_pkg::COUNT_W-1:0]   rem_nxt;
  logic [dmc_pkg::QUOT_W-1:0]    sh_nxt;

  logic                          out_free;
  logic                          load_out;
  dmc_pkg::entry_t               out_ent_r;
  logic [dmc_pkg::AVG_W-1:0]     out_avg_r;
  logic                          out_valid_r;

  // Numerator misses * penalty in Q8; its upper part is already below the divisor
  assign prod = dmc_pkg::PROD_W'(q_entry.miss_count) *
                dmc_pkg::PROD_W'(dmc_pkg::PENALTY_Q8);

  // One restoring division step
  always_comb begin
    trial   = {rem_r, sh_r[dmc_pkg::QUOT_W-1]};
    dvs     = {1'b0, ent_r.access_count};
    qbit    = (trial >= dvs);
    rem_nxt = qbit ? dmc_pkg::COUNT_W'(trial - dvs) : dmc_pkg::COUNT_W'(trial);
    sh_nxt  = {sh_r[dmc_pkg::QUOT_W-2:0], qbit};
  end

  assign out_free = !out_valid_r || out_ready;
  assign load_out = (state_r == ST_DONE) && out_free;
  assign pop      = q_valid && ((state_r == ST_IDLE) || load_out);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == dmc_pkg::STEP_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = pop ? ST_DIV : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load a new beat or advance the divider
  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r  <= q_entry;
      rem_r  <= prod[dmc_pkg::PROD_W-1:dmc_pkg::QUOT_W];
      sh_r   <= prod[dmc_pkg::QUOT_W-1:0];
      step_r <= dmc_pkg::STEP_W'(dmc_pkg::DIV_STEPS);
    end else if (state_r == ST_DIV) begin
      rem_r  <= rem_nxt;
      sh_r   <= sh_nxt;
      step_r <= step_r - dmc_pkg::STEP_W'(1);
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ent_r <= ent_r;
      out_avg_r <= dmc_pkg::AVG_W'({ent_r.hit_time, dmc_pkg::FRAC_W'(0)}) +
                   dmc_pkg::AVG_W'(sh_r);
    end
  end

  // Output register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_hit                = out_ent_r.hit;
  assign out_line_index         = out_ent_r.line_index;
  assign out_tag_value          = out_ent_r.tag_value;
  assign out_access_count       = out_ent_r.access_count;
  assign out_hit_count          = out_ent_r.hit_count;
  assign out_miss_count         = out_ent_r.miss_count;
  assign out_avg_access_time_q8 = out_avg_r;

endmodule

`default_nettype wire

@@ src/direct_mapped_cache_tag_check.sv @@
// Top level of the direct-mapped cache tag check: configuration registers,
// lookup front, queue and divider back end. Depends on dmc_pkg.
//
// Each address is split into byte offset, line index and tag using the
// offset_bits and index_bits registers, looked up in a direct-mapped line
// store (valid bit and tag per line) and filled on a miss. Each access gives
// one result with the hit flag, index, tag, saturating access/hit/miss
// counts and the average access time cache_clock + 120*misses/accesses in
// unsigned Q8, truncated. After reset the valid bits are swept clear, one
// line per cycle, over min(MAX_LINES, 1024) lines; in_ready stays low
// during the sweep while configuration writes are still taken. The front
// takes one address per cycle while its four-entry queue can hold it and
// the beat in lookup. The average is produced by a radix-2 restoring
// divider that works on one beat at a time; while busy it takes the next
// queued beat only as it loads a result into the output register. Write
// configuration only while idle.
`default_nettype none

module direct_mapped_cache_tag_check #(
  parameter int MAX_LINES     = 1024,
  parameter int ADDRESS_WIDTH = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ADDRESS_WIDTH-1:0]           in_address,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_hit,
  output logic [dmc_pkg::INDEX_OUT_W-1:0]         out_line_index,
  output logic [dmc_pkg::TAG_OUT_W-1:0]           out_tag_value,
  output logic [dmc_pkg::COUNT_W-1:0]             out_access_count,
  output logic [dmc_pkg::COUNT_W-1:0]             out_hit_count,
  output logic [dmc_pkg::COUNT_W-1:0]             out_miss_count,
  output logic [dmc_pkg::AVG_W-1:0]               out_avg_access_time_q8,
  input  wire logic                               cfg_we,
  input  wire logic [dmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dmc_pkg::CFG_W-1:0]          cfg_wdata
);

  dmc_pkg::cfg_t               cfg_r;
  dmc_pkg::cfg_t               cfg_nxt;
  logic                        push;
  dmc_pkg::entry_t             push_entry;
  logic                        pop;
  dmc_pkg::entry_t             pop_entry;
  logic                        q_not_empty;
  logic [dmc_pkg::QCNT_W-1:0]  q_count;

  // Register write decode; unknown indexes drop the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dmc_pkg::REG_OFFSET_BITS: cfg_nxt.offset_bits = cfg_wdata;
        dmc_pkg::REG_INDEX_BITS:  cfg_nxt.index_bits  = cfg_wdata;
        dmc_pkg::REG_CACHE_CLOCK: cfg_nxt.cache_clock = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= dmc_pkg::OFFSET_BITS_RST;
      cfg_r.index_bits  <= dmc_pkg::INDEX_BITS_RST;
      cfg_r.cache_clock <= dmc_pkg::CACHE_CLOCK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dmc_front #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_LINES     (MAX_LINES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_address (in_address),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  dmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty),
    .count      (q_count)
  );

  dmc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_not_empty),
    .q_entry                (pop_entry),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_hit                (out_hit),
    .out_line_index         (out_line_index),
    .out_tag_value          (out_tag_value),
    .out_access_count       (out_access_count),
    .out_hit_count          (out_hit_count),
    .out_miss_count         (out_miss_count),
    .out_avg_access_time_q8 (out_avg_access_time_q8)
  );

endmodule

`default_nettype wire

@@ src/dmc_checker.sv @@
// Port checker for the direct-mapped cache tag check, bound to the top level.
// Depends on dmc_pkg and direct_mapped_cache_tag_check_defines.svh.
`default_nettype none
`include "direct_mapped_cache_tag_check_defines.svh"

module dmc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_hit,
  input wire logic [dmc_pkg::INDEX_OUT_W-1:0] out_line_index,
  input wire logic [dmc_pkg::TAG_OUT_W-1:0] out_tag_value,
  input wire logic [dmc_pkg::COUNT_W-1:0]   out_access_count,
  input wire logic [dmc_pkg::COUNT_W-1:0]   out_hit_count,
  input wire logic [dmc_pkg::COUNT_W-1:0]   out_miss_count,
  input wire logic [dmc_pkg::AVG_W-1:0]     out_avg_access_time_q8
);

  // Stalled result beat holds
  `DMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_line_index) && $stable(out_tag_value) && $stable(out_access_count) && $stable(out_hit_count) && $stable(out_miss_count) && $stable(out_avg_access_time_q8), "result changed while stalled")

  // Hits and misses never exceed accesses
  `DMC_ASSERT_IMPL(a_count_order, out_valid, (out_miss_count <= out_access_count) && (out_hit_count <= out_access_count), "hit or miss count above access count")

  // Average in Q8 lies between the least hit time alone and the largest hit time plus the full penalty
  `DMC_ASSERT_IMPL(a_avg_range, out_valid, (out_avg_access_time_q8 >= 16'd256) && (out_avg_access_time_q8 <= 16'd33280), "average access time out of range")

  // The current access is included in its own counter
  `DMC_ASSERT_IMPL(a_hit_counted, out_valid, out_hit ? (out_hit_count != '0) : (out_miss_count != '0), "classification not counted")

endmodule

bind direct_mapped_cache_tag_check dmc_checker u_dmc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_hit                (out_hit),
  .out_line_index         (out_line_index),
  .out_tag_value          (out_tag_value),
  .out_access_count       (out_access_count),
  .out_hit_count          (out_hit_count),
  .out_miss_count         (out_miss_count),
  .out_avg_access_time_q8 (out_avg_access_time_q8)
);

`default_nettype wire
